[rtl/core/aabb_all_pairs_collision_core_assert.svh]
// ---------------------------------------------------------------------------
// aabb all-pairs collision core: assertion macros
// shorthand for clocked implication checks with asynchronous reset
// ---------------------------------------------------------------------------
`ifndef AABB_ALL_PAIRS_COLLISION_CORE_ASSERT_SVH
`define AABB_ALL_PAIRS_COLLISION_CORE_ASSERT_SVH

// same-cycle implication
`define AAPC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("aapc check failed");

// next-cycle implication
`define AAPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("aapc check failed");

`endif

[rtl/core/aapc_pkg.sv]
// ---------------------------------------------------------------------------
// aapc_pkg
// shared constants and types of the box collision core
// ---------------------------------------------------------------------------
package aapc_pkg;

	localparam int MAX_BOXES = 8;
	localparam int IDX_W     = $clog2(MAX_BOXES);
	localparam int STEP_W    = $clog2(MAX_BOXES + 1);
	localparam int SLOT_W    = 3;
	localparam int COORD_W   = 16;
	localparam int LEN_W     = 15;
	localparam int EDGE_W    = COORD_W + 1;
	localparam int OVL_W     = EDGE_W + 1;
	localparam int EPS_W     = 12;
	localparam int CMD_W     = 2;

	localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_SWEEP  = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_FLUSH
	} seq_state_t;

	typedef struct packed {
		logic                      active;
		logic signed [COORD_W-1:0] left;
		logic signed [COORD_W-1:0] top;
		logic signed [EDGE_W-1:0]  right;
		logic signed [EDGE_W-1:0]  bottom;
	} box_t;

	typedef struct packed {
		logic                      vld;
		logic [IDX_W-1:0]          idx;
		logic signed [COORD_W-1:0] left;
		logic signed [COORD_W-1:0] top;
		logic signed [EDGE_W-1:0]  right;
		logic signed [EDGE_W-1:0]  bottom;
	} probe_t;

	typedef struct packed {
		logic             adv;
		logic             inject;
		logic [IDX_W-1:0] probe_idx;
	} seq_ctl_t;

endpackage

[rtl/core/aapc_if.sv]
// ---------------------------------------------------------------------------
// aapc interfaces
// request, response and epsilon write channels with valid/ready
// ---------------------------------------------------------------------------
interface aapc_req_if;
	logic                               valid;
	logic                               ready;
	logic [aapc_pkg::CMD_W-1:0]         cmd;
	logic [aapc_pkg::SLOT_W-1:0]        slot;
	logic                               active;
	logic signed [aapc_pkg::COORD_W-1:0] left;
	logic signed [aapc_pkg::COORD_W-1:0] top;
	logic [aapc_pkg::LEN_W-1:0]         box_width;
	logic [aapc_pkg::LEN_W-1:0]         box_height;

	modport source (output valid, cmd, slot, active, left, top, box_width, box_height,
		input ready);
	modport sink (input valid, cmd, slot, active, left, top, box_width, box_height,
		output ready);
endinterface

interface aapc_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [aapc_pkg::SLOT_W-1:0] first_index;
	logic [aapc_pkg::SLOT_W-1:0] second_index;
	logic                        found;
	logic                        last;

	modport source (output valid, first_index, second_index, found, last, input ready);
	modport sink (input valid, first_index, second_index, found, last, output ready);
endinterface

interface aapc_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [aapc_pkg::EPS_W-1:0] overlap_epsilon;

	modport source (output valid, overlap_epsilon, input ready);
	modport sink (input valid, overlap_epsilon, output ready);
endinterface

[rtl/core/aapc_cell.sv]
// ---------------------------------------------------------------------------
// aapc_cell
// one table slot: holds its box and tests the probe passing through
// ---------------------------------------------------------------------------
module aapc_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [aapc_pkg::IDX_W-1:0]  cell_idx,
	input  logic                        wr_en,
	input  logic                        rm_en,
	input  aapc_pkg::box_t              wr_box,
	input  logic                        adv,
	input  logic [aapc_pkg::EPS_W-1:0]  eps,
	input  aapc_pkg::probe_t            probe_in,
	output aapc_pkg::probe_t            probe_out,
	output aapc_pkg::box_t              box,
	output logic                        box_valid,
	output logic                        hit
);

	localparam int EDGE_W = aapc_pkg::EDGE_W;
	localparam int OVL_W  = aapc_pkg::OVL_W;

	logic                               valid_q;
	logic                               active_q;
	logic signed [aapc_pkg::COORD_W-1:0] left_q;
	logic signed [aapc_pkg::COORD_W-1:0] top_q;
	logic signed [aapc_pkg::EDGE_W-1:0]  right_q;
	logic signed [aapc_pkg::EDGE_W-1:0]  bottom_q;
	logic                               pvld_q;
	aapc_pkg::probe_t                   probe_q;

	logic signed [aapc_pkg::EDGE_W-1:0] hi_x, hi_y, lo_x, lo_y;
	logic signed [aapc_pkg::OVL_W-1:0]  ov_x, ov_y, eps_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			active_q <= 1'b0;
			pvld_q   <= 1'b0;
		end else begin
			if (rm_en) begin
				valid_q <= 1'b0;
			end
			if (wr_en) begin
				valid_q  <= 1'b1;
				active_q <= wr_box.active;
			end
			if (adv) begin
				pvld_q <= probe_in.vld;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			left_q   <= wr_box.left;
			top_q    <= wr_box.top;
			right_q  <= wr_box.right;
			bottom_q <= wr_box.bottom;
		end
		if (adv) begin
			probe_q <= probe_in;
		end
	end

	// overlap per axis: smaller far edge minus larger near edge
	always_comb begin
		hi_x  = (right_q < probe_q.right) ? right_q : probe_q.right;
		hi_y  = (bottom_q < probe_q.bottom) ? bottom_q : probe_q.bottom;
		lo_x  = (left_q > probe_q.left) ? EDGE_W'(left_q) : EDGE_W'(probe_q.left);
		lo_y  = (top_q > probe_q.top) ? EDGE_W'(top_q) : EDGE_W'(probe_q.top);
		ov_x  = OVL_W'(hi_x) - OVL_W'(lo_x);
		ov_y  = OVL_W'(hi_y) - OVL_W'(lo_y);
		eps_s = $signed({{(aapc_pkg::OVL_W - aapc_pkg::EPS_W){1'b0}}, eps});
		hit   = pvld_q && valid_q && active_q && (cell_idx > probe_q.idx)
			&& (ov_x >= eps_s) && (ov_y >= eps_s);
	end

	always_comb begin
		probe_out     = probe_q;
		probe_out.vld = pvld_q;
		box.active    = active_q;
		box.left      = left_q;
		box.top       = top_q;
		box.right     = right_q;
		box.bottom    = bottom_q;
		box_valid     = valid_q;
	end

endmodule

[rtl/core/aapc_seq.sv]
// ---------------------------------------------------------------------------
// aapc_seq
// sweep sequencer: injects one probe per slot, orders hits, drives results
// ---------------------------------------------------------------------------
module aapc_seq (
	input  logic              clk,
	input  logic              arst_n,
	aapc_req_if.sink          req,
	aapc_rsp_if.source        rsp,
	input  logic              hit,
	output aapc_pkg::seq_ctl_t ctl
);

	aapc_pkg::seq_state_t               state_q, state_d;
	logic [aapc_pkg::IDX_W-1:0]         i_q;
	logic [aapc_pkg::STEP_W-1:0]        step_q;
	logic [aapc_pkg::STEP_W-1:0]        step_m1;
	logic [aapc_pkg::IDX_W-1:0]         j_idx;
	logic                               pend_vld_q;
	logic [aapc_pkg::IDX_W-1:0]         pend_i_q;
	logic [aapc_pkg::IDX_W-1:0]         pend_j_q;
	logic                               out_vld_q;
	logic [aapc_pkg::SLOT_W-1:0]        out_first_q;
	logic [aapc_pkg::SLOT_W-1:0]        out_second_q;
	logic                               out_found_q;
	logic                               out_last_q;

	logic out_free, adv, push, push_last, step_end, start;

	assign out_free = !out_vld_q || rsp.ready;
	assign start    = req.valid && req.ready && (req.cmd == aapc_pkg::CMD_SWEEP);
	assign step_m1  = step_q - aapc_pkg::STEP_W'(1);
	assign j_idx    = step_m1[aapc_pkg::IDX_W-1:0];
	assign step_end = (step_q == aapc_pkg::STEP_W'(aapc_pkg::MAX_BOXES));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= aapc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		adv       = 1'b0;
		push      = 1'b0;
		push_last = 1'b0;
		unique case (state_q)
			aapc_pkg::ST_IDLE: begin
				req.ready = 1'b1;
				if (start) begin
					state_d = aapc_pkg::ST_SWEEP;
				end
			end
			aapc_pkg::ST_SWEEP: begin
				// freeze the chain when a second hit finds the output busy
				adv  = !(hit && pend_vld_q && !out_free);
				push = adv && hit && pend_vld_q;
				if (adv && step_end && (i_q == aapc_pkg::IDX_W'(aapc_pkg::MAX_BOXES - 1))) begin
					state_d = aapc_pkg::ST_FLUSH;
				end
			end
			aapc_pkg::ST_FLUSH: begin
				if (out_free) begin
					push      = 1'b1;
					push_last = 1'b1;
					state_d   = aapc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = aapc_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q        <= '0;
			step_q     <= '0;
			pend_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			if (start) begin
				i_q    <= '0;
				step_q <= '0;
			end else if (adv) begin
				if (step_end) begin
					step_q <= '0;
					i_q    <= i_q + aapc_pkg::IDX_W'(1);
				end else begin
					step_q <= step_q + aapc_pkg::STEP_W'(1);
				end
			end
			if (adv && hit) begin
				pend_vld_q <= 1'b1;
			end else if (push_last) begin
				pend_vld_q <= 1'b0;
			end
			if (push) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && hit) begin
			pend_i_q <= i_q;
			pend_j_q <= j_idx;
		end
		if (push) begin
			out_first_q  <= pend_vld_q ? aapc_pkg::SLOT_W'(pend_i_q) : '0;
			out_second_q <= pend_vld_q ? aapc_pkg::SLOT_W'(pend_j_q) : '0;
			out_found_q  <= pend_vld_q;
			out_last_q   <= push_last;
		end
	end

	assign rsp.valid        = out_vld_q;
	assign rsp.first_index  = out_first_q;
	assign rsp.second_index = out_second_q;
	assign rsp.found        = out_found_q;
	assign rsp.last         = out_last_q;

	assign ctl.adv       = adv;
	assign ctl.inject    = adv && (step_q == '0);
	assign ctl.probe_idx = i_q;

endmodule

[rtl/core/aabb_all_pairs_collision_core.sv]
// ---------------------------------------------------------------------------
// aabb_all_pairs_collision_core
// table of axis-aligned boxes in a chain of slot cells with all-pairs sweep
// ---------------------------------------------------------------------------
//  channel  dir  payload
//  req      in   cmd, slot, active, left, top, box_width, box_height
//  rsp      out  first_index, second_index, found, last
//  cfg      in   overlap_epsilon
//
//  write and remove may follow back to back while idle
//  a sweep sends a probe for each valid active slot down the cell chain,
//  with only one probe in flight
//  the chain halts while a second hit waits on a stalled response
//  reset clears the valid marks and sets overlap_epsilon to zero
// ---------------------------------------------------------------------------
module aabb_all_pairs_collision_core (
	input  logic        clk,
	input  logic        arst_n,
	aapc_req_if.sink    req,
	aapc_rsp_if.source  rsp,
	aapc_cfg_if.sink    cfg
);

	localparam int N = aapc_pkg::MAX_BOXES;

	logic [aapc_pkg::EPS_W-1:0] eps_q;
	aapc_pkg::seq_ctl_t         ctl;
	aapc_pkg::probe_t           chain [N+1];
	aapc_pkg::box_t             boxes [N];
	logic [N-1:0]               box_valid;
	logic [N-1:0]               hits;
	aapc_pkg::box_t             wr_box;
	aapc_pkg::box_t             sel_box;
	logic                       sel_valid;
	logic                       accept;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= '0;
		end else if (cfg.valid) begin
			eps_q <= cfg.overlap_epsilon;
		end
	end

	assign accept = req.valid && req.ready;

	always_comb begin
		wr_box.active = req.active;
		wr_box.left   = req.left;
		wr_box.top    = req.top;
		wr_box.right  = $signed({req.left[aapc_pkg::COORD_W-1], req.left})
			+ $signed({2'b00, req.box_width});
		wr_box.bottom = $signed({req.top[aapc_pkg::COORD_W-1], req.top})
			+ $signed({2'b00, req.box_height});
	end

	// box under test for the probe about to enter the chain
	always_comb begin
		sel_box   = boxes[0];
		sel_valid = box_valid[0];
		for (int k = 1; k < N; k++) begin
			if (ctl.probe_idx == aapc_pkg::IDX_W'(k)) begin
				sel_box   = boxes[k];
				sel_valid = box_valid[k];
			end
		end
	end

	always_comb begin
		chain[0].vld    = ctl.inject && sel_valid && sel_box.active;
		chain[0].idx    = ctl.probe_idx;
		chain[0].left   = sel_box.left;
		chain[0].top    = sel_box.top;
		chain[0].right  = sel_box.right;
		chain[0].bottom = sel_box.bottom;
	end

	for (genvar k = 0; k < N; k++) begin : g_cell
		aapc_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cell_idx  (aapc_pkg::IDX_W'(k)),
			.wr_en     (accept && (req.cmd == aapc_pkg::CMD_WRITE) && (int'(req.slot) == k)),
			.rm_en     (accept && (req.cmd == aapc_pkg::CMD_REMOVE) && (int'(req.slot) == k)),
			.wr_box    (wr_box),
			.adv       (ctl.adv),
			.eps       (eps_q),
			.probe_in  (chain[k]),
			.probe_out (chain[k+1]),
			.box       (boxes[k]),
			.box_valid (box_valid[k]),
			.hit       (hits[k])
		);
	end

	aapc_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.hit    (|hits),
		.ctl    (ctl)
	);

endmodule

[rtl/core/aapc_checker.sv]
// ---------------------------------------------------------------------------
// aapc_checker
// port-level checks on the collision core, bound to the top level
// ---------------------------------------------------------------------------
`include "aabb_all_pairs_collision_core_assert.svh"

module aapc_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              req_valid,
	input logic                              req_ready,
	input logic [aapc_pkg::CMD_W-1:0]        req_cmd,
	input logic                              rsp_valid,
	input logic                              rsp_ready,
	input logic [aapc_pkg::SLOT_W-1:0]       rsp_first_index,
	input logic [aapc_pkg::SLOT_W-1:0]       rsp_second_index,
	input logic                              rsp_found,
	input logic                              rsp_last
);

	logic sweep_req;
	assign sweep_req = req_valid && req_ready && (req_cmd == aapc_pkg::CMD_SWEEP);

	`AAPC_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_last) && $stable(rsp_found))
	`AAPC_ASSERT_IMPLY(a_empty_is_last, clk, arst_n, rsp_valid && !rsp_found, rsp_last && rsp_first_index == '0 && rsp_second_index == '0)
	`AAPC_ASSERT_IMPLY(a_pair_order, clk, arst_n, rsp_valid && rsp_found, rsp_first_index < rsp_second_index)
	`AAPC_ASSERT_NEXT(a_sweep_busy, clk, arst_n, sweep_req, !req_ready)

endmodule

bind aabb_all_pairs_collision_core aapc_checker u_aapc_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_valid        (req.valid),
	.req_ready        (req.ready),
	.req_cmd          (req.cmd),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_first_index  (rsp.first_index),
	.rsp_second_index (rsp.second_index),
	.rsp_found        (rsp.found),
	.rsp_last         (rsp.last)
);
